// ===== src/rsl_pkg.sv =====
// Shared constants, payload types and the square root step of the spotlight block.
package rsl_pkg;

    // Field widths.
    localparam int COORD_BITS  = 12;
    localparam int LUMA_BITS   = 16;
    localparam int CENTER_BITS = 14;
    localparam int CFG_INDEX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = CFG_INDEX_W'(1);

    // Distance arithmetic. Offsets of 160 or more on either axis are far at once,
    // so the squares only ever see 8-bit offsets.
    localparam int DIFF_W   = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 2;
    localparam int ABS_W    = DIFF_W - 1;
    localparam int NEAR_W   = 8;
    localparam int NEAR_LIM = 160;
    localparam int SQR_W    = 2 * NEAR_W;
    localparam int SUM_W    = SQR_W + 1;
    localparam int FAR_SQ   = 25600;
    localparam int SQ_W     = 15;

    // Square root of sq * 2^16: 16 result bits, two per pipeline stage.
    localparam int SQRT_SHIFT      = 16;
    localparam int ROOT_W          = 16;
    localparam int REM_W           = ROOT_W + 1;
    localparam int RAD_W           = 2 * ROOT_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

    // Factor: F = floor((1638400 - 32 * D) / 25), division done by a reciprocal.
    // With m = ceil(2^26 / 25) the error term is 11 / 2^26 per unit of N, which
    // keeps the quotient exact for every N below 2^26 / 11.
    localparam int N_W         = 21;
    localparam int ONE_X25     = 1638400;
    localparam int D_SCALE_SH  = 5;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 22;
    localparam int RECIP_25    = (1 << RECIP_SHIFT) / 25 + 1;
    localparam int NPROD_W     = N_W + RECIP_W;
    localparam int F_W         = 17;
    localparam int FAR_FACTOR  = 13107;
    localparam int Q_FRAC      = 16;
    localparam int LPROD_W     = LUMA_BITS + F_W;

    typedef struct packed {
        logic [LUMA_BITS-1:0] luma;
        logic                 far;
        logic [SQ_W-1:0]      sq;
    } dist_t;

    typedef struct packed {
        logic [LUMA_BITS-1:0] luma;
        logic                 far;
        logic [ROOT_W-1:0]    root;
    } root_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    // One restoring step: bring down two radicand bits, try root*4+1.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [1:0] pair);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        sqrt_state_t      r;
        cur   = {s.rem, pair};
        trial = {1'b0, s.root, 2'b01};
        if (cur >= trial)
        begin
            r.rem  = REM_W'(cur - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(cur);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/rsl_dist.sv =====
// Three-stage front end: offsets from the center, squares, and the squared distance.
module rsl_dist (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [rsl_pkg::CENTER_BITS-1:0] center_x,
    input  logic signed [rsl_pkg::CENTER_BITS-1:0] center_y,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rsl_pkg::COORD_BITS-1:0]     pixel_x,
    input  logic [rsl_pkg::COORD_BITS-1:0]     pixel_y,
    input  logic [rsl_pkg::LUMA_BITS-1:0]      luma_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output rsl_pkg::dist_t                     out_data
);

    localparam int DW = rsl_pkg::DIFF_W;
    localparam int AW = rsl_pkg::ABS_W;
    localparam int NW = rsl_pkg::NEAR_W;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // Stage 1 registers.
    logic [AW-1:0]                  dx_reg, dy_reg;
    logic [rsl_pkg::LUMA_BITS-1:0]  luma1_reg;
    // Stage 2 registers.
    logic [rsl_pkg::SQR_W-1:0]      sqx_reg, sqy_reg;
    logic                           far2_reg;
    logic [rsl_pkg::LUMA_BITS-1:0]  luma2_reg;
    // Stage 3 registers.
    rsl_pkg::dist_t                 d3_reg;

    logic signed [DW-1:0]           px_ext, py_ext, cx_ext, cy_ext, diff_x, diff_y;
    logic [AW-1:0]                  dx_next, dy_next;
    logic [rsl_pkg::SQR_W-1:0]      sqx_next, sqy_next;
    logic                           far2_next;
    logic [rsl_pkg::SUM_W-1:0]      sum;
    rsl_pkg::dist_t                 d3_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        px_ext  = signed'({{(DW-rsl_pkg::COORD_BITS){1'b0}}, pixel_x});
        py_ext  = signed'({{(DW-rsl_pkg::COORD_BITS){1'b0}}, pixel_y});
        cx_ext  = {{(DW-rsl_pkg::CENTER_BITS){center_x[rsl_pkg::CENTER_BITS-1]}}, center_x};
        cy_ext  = {{(DW-rsl_pkg::CENTER_BITS){center_y[rsl_pkg::CENTER_BITS-1]}}, center_y};
        diff_x  = px_ext - cx_ext;
        diff_y  = py_ext - cy_ext;
        dx_next = diff_x[DW-1] ? AW'(-diff_x) : AW'(diff_x);
        dy_next = diff_y[DW-1] ? AW'(-diff_y) : AW'(diff_y);
    end

    always_comb
    begin
        far2_next = (dx_reg >= AW'(rsl_pkg::NEAR_LIM)) || (dy_reg >= AW'(rsl_pkg::NEAR_LIM));
        sqx_next  = rsl_pkg::SQR_W'(dx_reg[NW-1:0]) * rsl_pkg::SQR_W'(dx_reg[NW-1:0]);
        sqy_next  = rsl_pkg::SQR_W'(dy_reg[NW-1:0]) * rsl_pkg::SQR_W'(dy_reg[NW-1:0]);
    end

    always_comb
    begin
        sum          = rsl_pkg::SUM_W'(sqx_reg) + rsl_pkg::SUM_W'(sqy_reg);
        d3_next.luma = luma2_reg;
        d3_next.far  = far2_reg || (sum >= rsl_pkg::SUM_W'(rsl_pkg::FAR_SQ));
        d3_next.sq   = d3_next.far ? '0 : sum[rsl_pkg::SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            luma1_reg <= luma_in;
        end
        if (rdy2)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            far2_reg  <= far2_next;
            luma2_reg <= luma1_reg;
        end
        if (rdy3)
            d3_reg <= d3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// ===== src/rsl_sqrt.sv =====
// Pipelined integer square root of sq * 2^16, two result bits per stage.
module rsl_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rsl_pkg::dist_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rsl_pkg::root_t out_data
);

    localparam int NS   = rsl_pkg::SQRT_STAGES;
    localparam int LAST = NS - 1;

    logic                 vld_reg [NS];
    logic                 rdy     [NS];
    rsl_pkg::dist_t       dat_reg [NS];
    rsl_pkg::sqrt_state_t st_reg  [NS];

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_stage
            localparam int HI_STEP = rsl_pkg::ROOT_W - 1 - rsl_pkg::STEPS_PER_STAGE * j;

            logic                         src_valid;
            rsl_pkg::dist_t               src_dat;
            rsl_pkg::sqrt_state_t         src_st;
            rsl_pkg::sqrt_state_t         mid;
            rsl_pkg::sqrt_state_t         st_next;
            logic [rsl_pkg::RAD_W-1:0]    rad;

            if (j == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_dat   = in_data;
                assign src_st    = '0;
            end
            else
            begin : g_rest
                assign src_valid = vld_reg[j-1];
                assign src_dat   = dat_reg[j-1];
                assign src_st    = st_reg[j-1];
            end

            if (j == LAST)
            begin : g_tail
                assign rdy[j] = !vld_reg[j] || out_ready;
            end
            else
            begin : g_body
                assign rdy[j] = !vld_reg[j] || rdy[j+1];
            end

            always_comb
            begin
                rad     = rsl_pkg::RAD_W'(src_dat.sq) << rsl_pkg::SQRT_SHIFT;
                mid     = rsl_pkg::sqrt_step(src_st, rad[2*HI_STEP+1 -: 2]);
                st_next = rsl_pkg::sqrt_step(mid, rad[2*HI_STEP-1 -: 2]);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else if (rdy[j])
                    vld_reg[j] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[j])
                begin
                    dat_reg[j] <= src_dat;
                    st_reg[j]  <= st_next;
                end
            end
        end
    endgenerate

    assign in_ready       = rdy[0];
    assign out_valid      = vld_reg[LAST];
    assign out_data.luma  = dat_reg[LAST].luma;
    assign out_data.far   = dat_reg[LAST].far;
    assign out_data.root  = st_reg[LAST].root;

endmodule

// ===== src/rsl_scale.sv =====
// Two-stage back end: falloff factor by reciprocal multiply, then luminance scaling.
module rsl_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rsl_pkg::root_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rsl_pkg::LUMA_BITS-1:0] luma_out
);

    logic va_reg, vb_reg;
    logic rdya, rdyb;

    logic [rsl_pkg::NPROD_W-1:0]   nprod_reg, nprod_next;
    logic [rsl_pkg::LUMA_BITS-1:0] lumaa_reg;
    logic                          fara_reg;
    logic [rsl_pkg::LPROD_W-1:0]   lprod_reg, lprod_next;
    logic [rsl_pkg::N_W-1:0]       numer;
    logic [rsl_pkg::F_W-1:0]       factor;

    assign rdyb     = !vb_reg || out_ready;
    assign rdya     = !va_reg || rdyb;
    assign in_ready = rdya;

    always_comb
    begin
        numer      = rsl_pkg::N_W'(rsl_pkg::ONE_X25)
                   - {in_data.root, {rsl_pkg::D_SCALE_SH{1'b0}}};
        nprod_next = rsl_pkg::NPROD_W'(numer)
                   * rsl_pkg::NPROD_W'(rsl_pkg::RECIP_25);
    end

    always_comb
    begin
        factor     = fara_reg ? rsl_pkg::F_W'(rsl_pkg::FAR_FACTOR)
                              : nprod_reg[rsl_pkg::RECIP_SHIFT +: rsl_pkg::F_W];
        lprod_next = rsl_pkg::LPROD_W'(lumaa_reg) * rsl_pkg::LPROD_W'(factor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdya)
                va_reg <= in_valid;
            if (rdyb)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdya)
        begin
            nprod_reg <= nprod_next;
            lumaa_reg <= in_data.luma;
            fara_reg  <= in_data.far;
        end
        if (rdyb)
            lprod_reg <= lprod_next;
    end

    assign out_valid = vb_reg;
    assign luma_out  = lprod_reg[rsl_pkg::Q_FRAC +: rsl_pkg::LUMA_BITS];

endmodule

// ===== src/radial_spotlight_luminance.sv =====
// Top level of the radial spotlight luminance block: registers, pipeline and checks.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, pixel_x, pixel_y, luma_in | pixel in
//  out     | out_valid, out_ready, luma_out               | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | register write
//
// One pixel is taken per clock unless the pipeline is stalled. The pipeline holds
// three stages of distance arithmetic, eight square root stages of two result
// bits each, and two stages for the factor multiply and the luminance multiply.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the center to 0.
// Each stage holds its item while the stage after it is full and stalled; ready
// ripples back only through full stages, so bubbles are filled during a stall.
// The configuration channel is always ready; a write to an unknown index is dropped.
//
// The luminance of each pixel is scaled by a falloff factor that depends on its
// Euclidean distance from the configured center. A squared distance of 25600 or
// more gives the fixed factor 0.2; closer pixels get 1 - 0.005 * distance, with
// the distance taken as a Q8.8 truncated square root and the factor in Q1.16.
module radial_spotlight_luminance (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rsl_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [rsl_pkg::CENTER_BITS-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [rsl_pkg::COORD_BITS-1:0]         pixel_x,
    input  logic [rsl_pkg::COORD_BITS-1:0]         pixel_y,
    input  logic [rsl_pkg::LUMA_BITS-1:0]          luma_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [rsl_pkg::LUMA_BITS-1:0]          luma_out
);

    logic signed [rsl_pkg::CENTER_BITS-1:0] center_x_reg, center_x_next;
    logic signed [rsl_pkg::CENTER_BITS-1:0] center_y_reg, center_y_next;

    logic           dist_valid, dist_ready;
    rsl_pkg::dist_t dist_data;
    logic           root_valid, root_ready;
    rsl_pkg::root_t root_data;

    // Configuration writes go straight into the center registers, so the channel never stalls.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rsl_pkg::REG_CENTER_X: center_x_next = signed'(cfg_data);
                rsl_pkg::REG_CENTER_Y: center_y_next = signed'(cfg_data);
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

    // Offsets, squares and the far test.
    rsl_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .luma_in   (luma_in),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_data  (dist_data)
    );

    // Distance in Q8.8.
    rsl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_valid),
        .in_ready  (dist_ready),
        .in_data   (dist_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    // Factor and scaled luminance; its last register drives the output port.
    rsl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_ready  (root_ready),
        .in_data   (root_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .luma_out  (luma_out)
    );

`ifndef SYNTHESIS
    // A near item leaving the front end must have a squared distance below the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && !dist_data.far |-> dist_data.sq < rsl_pkg::SQ_W'(rsl_pkg::FAR_SQ))
    else $error("near item with squared distance past the far limit");

    // The root of a near item stays below 160 in Q8.8.
    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && !root_data.far |-> root_data.root < rsl_pkg::ROOT_W'(40960))
    else $error("square root out of range for a near item");

    // An item stalled between the front end and the root pipeline holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && !dist_ready |=> dist_valid && $stable(dist_data))
    else $error("stalled distance item changed or vanished");

    // The same between the root pipeline and the scaler.
    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && !root_ready |=> root_valid && $stable(root_data))
    else $error("stalled root item changed or vanished");
`endif

endmodule
